// ----- src/hfk_pkg.sv -----
// Package for the halfwidth to fullwidth katakana unit: code point constants,
// the result word type and the halfwidth to fullwidth lookup.
// No dependencies.
`default_nettype none

package hfk_pkg;

   localparam int CHAR_W = 21;
   localparam int BASE_W = 16;

   // Result queue depth: a power of two, two words of room above the ready limit.
   localparam int FIFO_DEPTH = 4;

   localparam logic [CHAR_W-1:0] HW_FIRST    = 21'h00ff65;
   localparam logic [CHAR_W-1:0] HW_LAST     = 21'h00ff9d;
   localparam logic [CHAR_W-1:0] MARK_VOICED = 21'h00ff9e;
   localparam logic [CHAR_W-1:0] MARK_SEMI   = 21'h00ff9f;
   localparam logic [CHAR_W-1:0] KA_FIRST    = 21'h00ff76;
   localparam logic [CHAR_W-1:0] KA_LAST     = 21'h00ff84;
   localparam logic [CHAR_W-1:0] HA_FIRST    = 21'h00ff8a;
   localparam logic [CHAR_W-1:0] HA_LAST     = 21'h00ff8e;

   localparam logic [BASE_W-1:0] FW_HA = 16'h30cf;
   localparam logic [BASE_W-1:0] FW_HI = 16'h30d2;
   localparam logic [BASE_W-1:0] FW_FU = 16'h30d5;
   localparam logic [BASE_W-1:0] FW_HE = 16'h30d8;
   localparam logic [BASE_W-1:0] FW_HO = 16'h30db;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              run_end;
      logic              string_end;
   } result_type;

   // Fullwidth code for halfwidth index (code point minus U+FF65).
   function automatic logic [BASE_W-1:0] fw_lookup(input logic [5:0] idx);
      logic [BASE_W-1:0] z;
      unique case (idx)
         6'd0:  z = 16'h30fb;  6'd1:  z = 16'h30f2;  6'd2:  z = 16'h30a1;
         6'd3:  z = 16'h30a3;  6'd4:  z = 16'h30a5;  6'd5:  z = 16'h30a7;
         6'd6:  z = 16'h30a9;  6'd7:  z = 16'h30e3;  6'd8:  z = 16'h30e5;
         6'd9:  z = 16'h30e7;  6'd10: z = 16'h30c3;  6'd11: z = 16'h30fc;
         6'd12: z = 16'h30a2;  6'd13: z = 16'h30a4;  6'd14: z = 16'h30a6;
         6'd15: z = 16'h30a8;  6'd16: z = 16'h30aa;  6'd17: z = 16'h30ab;
         6'd18: z = 16'h30ad;  6'd19: z = 16'h30af;  6'd20: z = 16'h30b1;
         6'd21: z = 16'h30b3;  6'd22: z = 16'h30b5;  6'd23: z = 16'h30b7;
         6'd24: z = 16'h30b9;  6'd25: z = 16'h30bb;  6'd26: z = 16'h30bd;
         6'd27: z = 16'h30bf;  6'd28: z = 16'h30c1;  6'd29: z = 16'h30c4;
         6'd30: z = 16'h30c6;  6'd31: z = 16'h30c8;  6'd32: z = 16'h30ca;
         6'd33: z = 16'h30cb;  6'd34: z = 16'h30cc;  6'd35: z = 16'h30cd;
         6'd36: z = 16'h30ce;  6'd37: z = 16'h30cf;  6'd38: z = 16'h30d2;
         6'd39: z = 16'h30d5;  6'd40: z = 16'h30d8;  6'd41: z = 16'h30db;
         6'd42: z = 16'h30de;  6'd43: z = 16'h30df;  6'd44: z = 16'h30e0;
         6'd45: z = 16'h30e1;  6'd46: z = 16'h30e2;  6'd47: z = 16'h30e4;
         6'd48: z = 16'h30e6;  6'd49: z = 16'h30e8;  6'd50: z = 16'h30e9;
         6'd51: z = 16'h30ea;  6'd52: z = 16'h30eb;  6'd53: z = 16'h30ec;
         6'd54: z = 16'h30ed;  6'd55: z = 16'h30ef;  6'd56: z = 16'h30f3;
         default: z = 16'h0000;
      endcase
      return z;
   endfunction

   function automatic logic [CHAR_W-1:0] to_full(input logic [CHAR_W-1:0] c);
      logic [15:0] off;
      off = c[15:0] - HW_FIRST[15:0];
      if (c >= HW_FIRST && c <= HW_LAST) begin
         return {5'b0, fw_lookup(off[5:0])};
      end
      return c;
   endfunction

   // Halfwidth ka..to and ha..ho: may combine with a following mark.
   function automatic logic holdable(input logic [CHAR_W-1:0] c);
      return (c >= KA_FIRST && c <= KA_LAST) || (c >= HA_FIRST && c <= HA_LAST);
   endfunction

   function automatic logic takes_semi(input logic [BASE_W-1:0] z);
      return z == FW_HA || z == FW_HI || z == FW_FU || z == FW_HE || z == FW_HO;
   endfunction

endpackage

`default_nettype wire

// ----- src/halfwidth_to_fullwidth_katakana_unit.sv -----
// Halfwidth to fullwidth katakana unit: converts a code point stream and
// composes voiced marks. Depends on hfk_pkg.
//
// A result word is written into the result queue when its input word is taken;
// a voicable base waits in the hold register for the next input word.
// Throughput: one input word per cycle while the queue is at or under READY_MAX;
// two results of one word leave by two transfers from the FIFO_DEPTH-entry queue.
// Reset: synchronous, clears the hold flag and empties the result queue.
`default_nettype none

module halfwidth_to_fullwidth_katakana_unit
   import hfk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [20:0] in_char, [23:21] zero
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [20:0] out_char, [23:21] zero
   output logic             rsp_tlast,   // run_end
   output logic             rsp_tuser    // [0] string_end
);

   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int COUNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_ONE   = PTR_W'(1);
   localparam logic [COUNT_W-1:0] READY_MAX = COUNT_W'(FIFO_DEPTH - 2);

   logic                 held_ff, held_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   result_type           fifo_ff [FIFO_DEPTH];
   result_type           fifo_in [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [CHAR_W-1:0]    c;
   logic                 last;
   logic                 hold_c;
   logic [CHAR_W-1:0]    fw_c;
   logic [BASE_W-1:0]    base_voiced, base_semi;
   logic                 req_fire, rsp_fire;
   logic [1:0]           push_n;
   result_type           r0, r1;
   result_type           head;

   assign c        = req_tdata[CHAR_W-1:0];
   assign last     = req_tlast;
   assign hold_c   = holdable(c);
   assign fw_c     = to_full(c);
   assign base_voiced = base_ff + 16'd1;
   assign base_semi   = base_ff + 16'd2;

   assign req_tready = count_ff <= READY_MAX;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Results for the current word against the hold register.
   always_comb begin
      held_in = held_ff;
      base_in = base_ff;
      push_n  = 2'd0;
      r0      = '{out_char: fw_c, run_end: 1'b1, string_end: last};
      r1      = '{out_char: fw_c, run_end: 1'b1, string_end: last};
      if (req_fire) begin
         if (held_ff) begin
            held_in = 1'b0;
            push_n  = 2'd1;
            priority if (c == MARK_VOICED) begin
               r0.out_char = {5'b0, base_voiced};
            end else if (c == MARK_SEMI && takes_semi(base_ff)) begin
               r0.out_char = {5'b0, base_semi};
            end else if (hold_c && !last) begin
               held_in = 1'b1;
               base_in = fw_c[BASE_W-1:0];
               r0      = '{out_char: {5'b0, base_ff}, run_end: 1'b1, string_end: 1'b0};
            end else begin
               push_n = 2'd2;
               r0     = '{out_char: {5'b0, base_ff}, run_end: 1'b0, string_end: 1'b0};
            end
         end else if (hold_c && !last) begin
            held_in = 1'b1;
            base_in = fw_c[BASE_W-1:0];
         end else begin
            push_n = 2'd1;
         end
      end
   end

   // Result queue: push up to two words, pop one.
   always_comb begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         fifo_in[i] = fifo_ff[i];
         if (push_n != 2'd0 && PTR_W'(i) == wr_ptr_ff) begin
            fifo_in[i] = r0;
         end
         if (push_n == 2'd2 && PTR_W'(i) == wr_ptr_ff + PTR_ONE) begin
            fifo_in[i] = r1;
         end
      end
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rsp_fire ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(push_n) - COUNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         held_ff   <= held_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      fifo_ff <= fifo_in;
   end

   assign head      = fifo_ff[rd_ptr_ff];
   assign rsp_tdata = {3'b0, head.out_char};
   assign rsp_tlast = head.run_end;
   assign rsp_tuser = head.string_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_hold_base: assert property (@(posedge clock) disable iff (reset)
      req_fire && !held_ff && hold_c && !last |=>
         held_ff && rsp_tvalid == $past(rsp_tvalid && !rsp_fire || count_ff > 1))
      else $error("voicable base not held");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && last |=> !held_ff && rsp_tvalid)
      else $error("base left held at end of string");

   a_end_implies_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("string end without run end");

endmodule

`default_nettype wire

// ----- bench/halfwidth_to_fullwidth_katakana_unit_tb.sv -----
// Testbench for halfwidth_to_fullwidth_katakana_unit: drives code point strings,
// predicts the fullwidth conversion with voiced mark composition and checks each word.
// Depends on hfk_pkg and the unit itself.
`default_nettype none

module halfwidth_to_fullwidth_katakana_unit_tb
   import hfk_pkg::*;
();

   localparam int QUIET_LIMIT = 600;
   localparam int STALL_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [20:0] in_char, [23:21] zero
   logic        req_tlast = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [20:0] out_char, [23:21] zero
   logic        rsp_tlast;        // run_end
   logic        rsp_tuser;        // [0] string_end

   halfwidth_to_fullwidth_katakana_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // Fullwidth form per halfwidth offset from U+FF65.
   logic [15:0] full_form [0:56] = '{
      16'h30fb, 16'h30f2, 16'h30a1, 16'h30a3, 16'h30a5, 16'h30a7, 16'h30a9, 16'h30e3,
      16'h30e5, 16'h30e7, 16'h30c3, 16'h30fc, 16'h30a2, 16'h30a4, 16'h30a6, 16'h30a8,
      16'h30aa, 16'h30ab, 16'h30ad, 16'h30af, 16'h30b1, 16'h30b3, 16'h30b5, 16'h30b7,
      16'h30b9, 16'h30bb, 16'h30bd, 16'h30bf, 16'h30c1, 16'h30c4, 16'h30c6, 16'h30c8,
      16'h30ca, 16'h30cb, 16'h30cc, 16'h30cd, 16'h30ce, 16'h30cf, 16'h30d2, 16'h30d5,
      16'h30d8, 16'h30db, 16'h30de, 16'h30df, 16'h30e0, 16'h30e1, 16'h30e2, 16'h30e4,
      16'h30e6, 16'h30e8, 16'h30e9, 16'h30ea, 16'h30eb, 16'h30ec, 16'h30ed, 16'h30ef,
      16'h30f3
   };

   // predictor state: a voicable base waiting for a possible mark
   logic        held_on = 1'b0;
   logic [15:0] held_code = '0;

   result_type converted_queue [$];

   logic idle_on = 1'b0;
   logic hold_rsp = 1'b0;
   int   rsp_idle_left = 0;
   int   quiet_cycles = 0;
   int   mismatches = 0;
   int   words_sent = 0;
   int   results_checked = 0;
   int   composed_count = 0;

   function automatic logic [20:0] widen(input logic [20:0] c);
      logic [20:0] off;
      off = c - HW_FIRST;
      if (c >= HW_FIRST && c <= HW_LAST) begin
         return {5'b0, full_form[off[5:0]]};
      end
      return c;
   endfunction

   function automatic logic voicable(input logic [20:0] c);
      return (c >= KA_FIRST && c <= KA_LAST) || (c >= HA_FIRST && c <= HA_LAST);
   endfunction

   function automatic logic semi_ok(input logic [15:0] z);
      return z == FW_HA || z == FW_HI || z == FW_FU || z == FW_HE || z == FW_HO;
   endfunction

   function automatic void push_result(input logic [20:0] ch, input logic re,
                                       input logic se);
      result_type r;
      r.out_char = ch;
      r.run_end = re;
      r.string_end = se;
      converted_queue = {converted_queue, r};
   endfunction

   // Work out the results that one accepted word causes.
   function automatic void convert_word(input logic [20:0] c, input logic last);
      logic [15:0] z;
      logic [20:0] w;
      w = widen(c);
      if (held_on) begin
         z = held_code;
         held_on = 1'b0;
         held_code = '0;
         if (c == MARK_VOICED) begin
            push_result({5'b0, z + 16'd1}, 1'b1, last);
            composed_count++;
            return;
         end
         if (c == MARK_SEMI && semi_ok(z)) begin
            push_result({5'b0, z + 16'd2}, 1'b1, last);
            composed_count++;
            return;
         end
         if (voicable(c) && !last) begin
            held_on = 1'b1;
            held_code = w[15:0];
            push_result({5'b0, z}, 1'b1, 1'b0);
            return;
         end
         push_result({5'b0, z}, 1'b0, 1'b0);
      end else if (voicable(c) && !last) begin
         held_on = 1'b1;
         held_code = w[15:0];
         return;
      end
      push_result(w, 1'b1, last);
   endfunction

   task automatic send_word(input logic [20:0] c, input logic last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b0, c};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      convert_word(c, last);
      words_sent++;
   endtask

   function automatic logic [20:0] pick_base();
      if ($urandom_range(0, 2) == 0) begin
         return HA_FIRST + 21'($urandom_range(0, 4));
      end
      return KA_FIRST + 21'($urandom_range(0, 14));
   endfunction

   function automatic logic [20:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return pick_base();
      if (r < 40) return $urandom_range(0, 1) ? MARK_VOICED : MARK_SEMI;
      if (r < 65) return HW_FIRST + 21'($urandom_range(0, 56));
      if (r < 78) return 21'($urandom_range(0, 16'hffff));
      if (r < 90) return 21'($urandom_range(0, 21'h1fffff));
      case ($urandom_range(0, 7))
         0: return 21'h00ff64;
         1: return 21'h00ffa0;
         2: return KA_FIRST - 21'd1;
         3: return KA_LAST + 21'd1;
         4: return HA_FIRST - 21'd1;
         5: return HA_LAST + 21'd1;
         6: return 21'h10ffff;
         default: return 21'h110000;
      endcase
   endfunction

   // Mostly base plus mark pairs, some broken pairs, the rest loose characters.
   task automatic send_string();
      logic [20:0] word_list [$];
      int len;
      int r;
      len = $urandom_range(1, 8);
      while (word_list.size() < len) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            word_list = {word_list, pick_base()};
            word_list = {word_list, ($urandom_range(0, 1) ? MARK_VOICED : MARK_SEMI)};
         end else if (r < 70) begin
            word_list = {word_list, pick_base()};
            word_list = {word_list, pick_char()};
         end else begin
            word_list = {word_list, pick_char()};
         end
      end
      for (int i = 0; i < len; i++) begin
         send_word(word_list[i], i == len - 1);
      end
   endtask

   task automatic test_directed();
      idle_on <= 1'b1;
      send_word(21'h000000, 1'b1);
      send_word(21'h1fffff, 1'b1);
      send_word(21'h10ffff, 1'b0);
      send_word(21'h110000, 1'b1);
      send_word(HW_FIRST, 1'b0);
      send_word(HW_LAST, 1'b1);
      // lone marks pass through
      send_word(MARK_VOICED, 1'b0);
      send_word(MARK_SEMI, 1'b1);
      // dakuten composes, string end on the composed word
      send_word(KA_FIRST, 1'b0);
      send_word(MARK_VOICED, 1'b1);
      send_word(HA_LAST, 1'b0);
      send_word(MARK_SEMI, 1'b0);
      // handakuten on ka..to does not combine
      send_word(KA_LAST, 1'b0);
      send_word(MARK_SEMI, 1'b0);
      // held base followed by another base, then by a plain character
      send_word(HA_FIRST, 1'b0);
      send_word(KA_FIRST, 1'b0);
      send_word(21'h000041, 1'b0);
      // base with end of string goes out at once
      send_word(HA_FIRST, 1'b1);
      send_word(KA_FIRST, 1'b0);
      send_word(HA_LAST, 1'b1);
      send_word(HA_FIRST, 1'b0);
      send_word(MARK_VOICED, 1'b1);
      send_word(21'h00ff64, 1'b0);
      send_word(21'h00ffa0, 1'b1);
   endtask

   task automatic test_random_strings(input int n_words);
      int start;
      start = words_sent;
      while (words_sent - start < n_words) begin
         idle_on <= ($urandom_range(0, 3) != 0);
         send_string();
      end
   endtask

   // Receiver holds off while strings keep coming, so the result queue fills.
   task automatic test_backpressure();
      idle_on <= 1'b0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (STALL_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int i = 0; i < 10; i++) send_string();
         end
      join
   endtask

   task automatic test_steady_flow(input int n_words);
      int start;
      start = words_sent;
      idle_on <= 1'b0;
      while (words_sent - start < n_words) send_string();
   endtask

   task automatic note_mismatch(input result_type want, input logic [23:0] got_data,
                                input logic got_last, input logic got_user,
                                input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s): expected char %06h run_end %b string_end %b, got %06h %b %b",
                  what, want.out_char, want.run_end, want.string_end,
                  got_data, got_last, got_user);
      end
   endtask

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (rsp_idle_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_idle_left <= rsp_idle_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_idle_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (converted_queue.size() == 0) begin
            want = '0;
            note_mismatch(want, rsp_tdata, rsp_tlast, rsp_tuser, "unexpected word");
         end else begin
            want = converted_queue.pop_front();
            results_checked++;
            if (rsp_tdata !== {3'b0, want.out_char} || rsp_tlast !== want.run_end ||
                rsp_tuser !== want.string_end) begin
               note_mismatch(want, rsp_tdata, rsp_tlast, rsp_tuser, "field");
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_strings(620);
      test_backpressure();
      test_steady_flow(130);
      req_tvalid <= 1'b0;
      idle_on <= 1'b0;
      while (converted_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("run covered %0d input words and %0d result words, %0d of them composed",
               words_sent, results_checked, composed_count);
      $display("directed edges, random strings with idling, a long receiver stall; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
